### rtl/bpls_pkg.sv
// ----------------------------------------------------------------------------
// bpls_pkg
// Shared types and constants for the button press and LED sequencer.
// ----------------------------------------------------------------------------
package bpls_pkg;

  // timer width and saturation value
  localparam int unsigned TimerBits = 16;
  localparam logic [TimerBits-1:0] TimerMax = {TimerBits{1'b1}};

  // publish attempts before the failure flashes
  localparam logic [1:0] MaxAttempts = 2'd2;

  // configuration register port
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 16;

  localparam logic [CfgIdxBits-1:0] RegDebounce     = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegShortMin     = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegResetHold    = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegStep         = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegPostWait     = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegAuthHalf     = 3'd5;
  localparam logic [CfgIdxBits-1:0] RegFailFlash    = 3'd6;
  localparam logic [CfgIdxBits-1:0] RegRetryWait    = 3'd7;

  // register reset values
  localparam logic [7:0]           DebounceRst   = 8'd20;
  localparam logic [TimerBits-1:0] ShortMinRst   = 16'd50;
  localparam logic [TimerBits-1:0] ResetHoldRst  = 16'd10000;
  localparam logic [TimerBits-1:0] StepRst       = 16'd100;
  localparam logic [TimerBits-1:0] PostWaitRst   = 16'd500;
  localparam logic [TimerBits-1:0] AuthHalfRst   = 16'd500;
  localparam logic [TimerBits-1:0] FailFlashRst  = 16'd50;
  localparam logic [TimerBits-1:0] RetryWaitRst  = 16'd25;

  // command codes
  localparam logic [1:0] CmdNone    = 2'd0;
  localparam logic [1:0] CmdAuthOn  = 2'd1;
  localparam logic [1:0] CmdAuthOff = 2'd2;

  // led sequencer phases
  typedef enum logic [4:0] {
    PhIdle, PhPreOn1, PhPreOff1, PhPreOn2, PhPreOff2,
    PhTry, PhRetryWait, PhPostWait,
    PhPostOn1, PhPostOff1, PhPostOn2, PhPostOff2,
    PhFailOn1, PhFailOff1, PhFailOn2, PhFailOff2, PhFailOn3, PhFailOff3,
    PhAuthOn, PhAuthOff
  } phase_e;

  // input word: one millisecond tick
  typedef struct packed {
    logic       raw_button;
    logic [1:0] command;
    logic       publish_ok;
    logic       broker_configured;
    logic       access_point_mode;
    logic       update_in_progress;
  } bpls_in_t;

  // result word
  typedef struct packed {
    logic led_level;
    logic led_hold;
    logic publish_attempt;
    logic factory_reset_request;
    logic auth_short_press;
    logic sequence_active;
    logic auth_blink_active;
    logic button_level;
  } bpls_out_t;

  // configuration write word
  typedef struct packed {
    logic [CfgIdxBits-1:0]  index;
    logic [CfgDataBits-1:0] data;
  } bpls_cfg_t;

endpackage

### rtl/bpls_if.sv
// ----------------------------------------------------------------------------
// bpls channel interfaces
// Valid/ready channels for input ticks, results and configuration writes.
// ----------------------------------------------------------------------------

// input tick channel
interface bpls_in_if;
  logic              valid;
  logic              ready;
  bpls_pkg::bpls_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// result channel
interface bpls_out_if;
  logic               valid;
  logic               ready;
  bpls_pkg::bpls_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// configuration write channel
interface bpls_cfg_if;
  logic               valid;
  logic               ready;
  bpls_pkg::bpls_cfg_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/button_press_led_sequencer.sv
// ----------------------------------------------------------------------------
// button_press_led_sequencer
// One word on in_i is one millisecond tick; every tick gives exactly one
// result word on out_o. A tick is taken in every clock cycle while the result
// register is empty or being drained, so the block sustains one tick per
// cycle; the result register is the only stage between the two sides. Each
// tick applies the auth blink command, debounces the button, times the hold
// (long hold raises a one-tick factory reset request unless an update runs),
// classifies a release as a short press and advances the LED sequence by at
// most one phase. Configuration writes are always taken and must only be
// issued while no tick is in flight.
// ----------------------------------------------------------------------------
module button_press_led_sequencer (
  input  logic          clk_i,
  input  logic          rst_ni,
  bpls_in_if.sink       in_i,
  bpls_out_if.source    out_o,
  bpls_cfg_if.sink      cfg_i
);
  import bpls_pkg::*;

  // configuration registers
  logic [7:0]           debounce_q;
  logic [TimerBits-1:0] short_min_q, reset_hold_q, step_q, post_wait_q;
  logic [TimerBits-1:0] auth_half_q, fail_flash_q, retry_wait_q;

  // tick state
  logic                 raw_last_q, raw_last_d;
  logic                 stable_q, stable_d;
  logic [TimerBits-1:0] change_age_q, change_age_d;
  logic                 held_down_q, held_down_d;
  logic [TimerBits-1:0] held_time_q, held_time_d;
  logic                 reset_done_q, reset_done_d;
  phase_e               phase_q, phase_d;
  logic [TimerBits-1:0] elapsed_q, elapsed_d;
  logic [TimerBits-1:0] duration_q, duration_d;
  logic [1:0]           fail_cnt_q, fail_cnt_d;
  logic                 led_q, led_d;

  // result register
  logic                 out_valid_q;
  bpls_out_t            out_q, out_d;

  logic                 in_fire;
  logic                 attempt, reset_req, auth_press;

  assign in_fire     = in_i.valid && in_i.ready;
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DebounceRst;
      short_min_q  <= ShortMinRst;
      reset_hold_q <= ResetHoldRst;
      step_q       <= StepRst;
      post_wait_q  <= PostWaitRst;
      auth_half_q  <= AuthHalfRst;
      fail_flash_q <= FailFlashRst;
      retry_wait_q <= RetryWaitRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        RegDebounce:  debounce_q   <= cfg_i.data.data[7:0];
        RegShortMin:  short_min_q  <= cfg_i.data.data;
        RegResetHold: reset_hold_q <= cfg_i.data.data;
        RegStep:      step_q       <= cfg_i.data.data;
        RegPostWait:  post_wait_q  <= cfg_i.data.data;
        RegAuthHalf:  auth_half_q  <= cfg_i.data.data;
        RegFailFlash: fail_flash_q <= cfg_i.data.data;
        RegRetryWait: retry_wait_q <= cfg_i.data.data;
        default: ;
      endcase
    end
  end

  // tick update: command, debounce, hold timing, at most one phase step
  always_comb begin
    logic [TimerBits-1:0] fc_inc;
    fc_inc       = '0;
    raw_last_d   = raw_last_q;
    stable_d     = stable_q;
    change_age_d = change_age_q;
    held_down_d  = held_down_q;
    held_time_d  = held_time_q;
    reset_done_d = reset_done_q;
    phase_d      = phase_q;
    duration_d   = duration_q;
    fail_cnt_d   = fail_cnt_q;
    led_d        = led_q;
    attempt      = 1'b0;
    reset_req    = 1'b0;
    auth_press   = 1'b0;
    elapsed_d    = (elapsed_q == TimerMax) ? TimerMax : elapsed_q + 1'b1;

    // auth blink command
    case (in_i.data.command)
      CmdAuthOff: begin
        if (phase_d == PhAuthOn || phase_d == PhAuthOff) begin
          led_d   = 1'b0;
          phase_d = PhIdle;
        end
      end
      CmdAuthOn: begin
        if (phase_d == PhIdle) begin
          phase_d    = PhAuthOn;
          led_d      = 1'b1;
          elapsed_d  = '0;
          duration_d = auth_half_q;
        end
      end
      default: ;
    endcase

    // debounce
    if (in_i.data.raw_button != raw_last_q) begin
      raw_last_d   = in_i.data.raw_button;
      change_age_d = '0;
    end else begin
      change_age_d = (change_age_q == TimerMax) ? TimerMax : change_age_q + 1'b1;
    end
    if (change_age_d >= {{(TimerBits-8){1'b0}}, debounce_q}) begin
      stable_d = raw_last_d;
    end

    // hold timing and release classification
    if (stable_d) begin
      if (!held_down_q) begin
        held_down_d  = 1'b1;
        held_time_d  = '0;
        reset_done_d = 1'b0;
      end else begin
        held_time_d = (held_time_q == TimerMax) ? TimerMax : held_time_q + 1'b1;
        if (!reset_done_q && held_time_d >= reset_hold_q) begin
          reset_done_d = 1'b1;
          reset_req    = !in_i.data.update_in_progress;
        end
      end
    end else if (held_down_q) begin
      held_time_d = (held_time_q == TimerMax) ? TimerMax : held_time_q + 1'b1;
      if (!reset_done_q && held_time_d >= short_min_q && held_time_d < reset_hold_q) begin
        if (phase_d == PhAuthOn || phase_d == PhAuthOff) begin
          auth_press = 1'b1;
        end else if (phase_d == PhIdle && !in_i.data.access_point_mode &&
                     in_i.data.broker_configured) begin
          phase_d    = PhPreOn1;
          led_d      = 1'b1;
          elapsed_d  = '0;
          duration_d = step_q;
        end
      end
      held_down_d  = 1'b0;
      reset_done_d = 1'b0;
    end

    // led sequence step
    if (phase_d != PhIdle && !(elapsed_d < duration_d)) begin
      fc_inc = {{(TimerBits-2){1'b0}}, fail_cnt_q + 2'd1};
      unique case (phase_d)
        PhPreOn1:    begin led_d = 1'b0; phase_d = PhPreOff1;
                           elapsed_d = '0; duration_d = step_q; end
        PhPreOff1:   begin led_d = 1'b1; phase_d = PhPreOn2;
                           elapsed_d = '0; duration_d = step_q; end
        PhPreOn2:    begin led_d = 1'b0; phase_d = PhPreOff2;
                           elapsed_d = '0; duration_d = step_q; end
        PhPostWait:  begin led_d = 1'b1; phase_d = PhPostOn1;
                           elapsed_d = '0; duration_d = step_q; end
        PhPostOn1:   begin led_d = 1'b0; phase_d = PhPostOff1;
                           elapsed_d = '0; duration_d = step_q; end
        PhPostOff1:  begin led_d = 1'b1; phase_d = PhPostOn2;
                           elapsed_d = '0; duration_d = step_q; end
        PhPostOn2:   begin led_d = 1'b0; phase_d = PhPostOff2;
                           elapsed_d = '0; duration_d = step_q; end
        PhFailOn1:   begin led_d = 1'b0; phase_d = PhFailOff1;
                           elapsed_d = '0; duration_d = fail_flash_q; end
        PhFailOff1:  begin led_d = 1'b1; phase_d = PhFailOn2;
                           elapsed_d = '0; duration_d = fail_flash_q; end
        PhFailOn2:   begin led_d = 1'b0; phase_d = PhFailOff2;
                           elapsed_d = '0; duration_d = fail_flash_q; end
        PhFailOff2:  begin led_d = 1'b1; phase_d = PhFailOn3;
                           elapsed_d = '0; duration_d = fail_flash_q; end
        PhFailOn3:   begin led_d = 1'b0; phase_d = PhFailOff3;
                           elapsed_d = '0; duration_d = fail_flash_q; end
        PhAuthOn:    begin led_d = 1'b0; phase_d = PhAuthOff;
                           elapsed_d = '0; duration_d = auth_half_q; end
        PhAuthOff:   begin led_d = 1'b1; phase_d = PhAuthOn;
                           elapsed_d = '0; duration_d = auth_half_q; end
        PhPreOff2: begin
          fail_cnt_d = '0;
          phase_d    = PhTry;
          elapsed_d  = '0;
          duration_d = '0;
        end
        PhTry: begin
          attempt = 1'b1;
          if (in_i.data.publish_ok) begin
            phase_d    = PhPostWait;
            elapsed_d  = '0;
            duration_d = post_wait_q;
          end else begin
            fail_cnt_d = fc_inc[1:0];
            if (fc_inc[1:0] >= MaxAttempts) begin
              led_d      = 1'b1;
              phase_d    = PhFailOn1;
              elapsed_d  = '0;
              duration_d = fail_flash_q;
            end else begin
              phase_d    = PhRetryWait;
              elapsed_d  = '0;
              duration_d = retry_wait_q;
            end
          end
        end
        PhRetryWait: begin
          phase_d    = PhTry;
          elapsed_d  = '0;
          duration_d = '0;
        end
        PhPostOff2, PhFailOff3: phase_d = PhIdle;
        default: ;
      endcase
    end

    // result word
    out_d.led_level             = led_d;
    out_d.led_hold              = (phase_d == PhIdle);
    out_d.publish_attempt       = attempt;
    out_d.factory_reset_request = reset_req;
    out_d.auth_short_press      = auth_press;
    out_d.sequence_active       = (phase_d != PhIdle);
    out_d.auth_blink_active     = (phase_d == PhAuthOn || phase_d == PhAuthOff);
    out_d.button_level          = stable_d;
  end

  // state registers, updated once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_last_q   <= 1'b0;
      stable_q     <= 1'b0;
      change_age_q <= '0;
      held_down_q  <= 1'b0;
      held_time_q  <= '0;
      reset_done_q <= 1'b0;
      phase_q      <= PhIdle;
      elapsed_q    <= '0;
      duration_q   <= '0;
      fail_cnt_q   <= '0;
      led_q        <= 1'b0;
    end else if (in_fire) begin
      raw_last_q   <= raw_last_d;
      stable_q     <= stable_d;
      change_age_q <= change_age_d;
      held_down_q  <= held_down_d;
      held_time_q  <= held_time_d;
      reset_done_q <= reset_done_d;
      phase_q      <= phase_d;
      elapsed_q    <= elapsed_d;
      duration_q   <= duration_d;
      fail_cnt_q   <= fail_cnt_d;
      led_q        <= led_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  // an accepted tick always leaves a word in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted tick left no result word");

  // auth blink is a kind of active sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.auth_blink_active) |-> out_q.sequence_active)
    else $error("auth blink reported while sequencer idle");

  // a reset request only comes while the button is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.factory_reset_request) |-> out_q.button_level)
    else $error("reset request without held button");

  // a short press pulse only on release during auth blink
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.auth_short_press) |->
      (out_q.auth_blink_active && !out_q.button_level))
    else $error("auth short press outside auth blink release");

endmodule

### tb/bpls_sequence_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpls_sequence_checker
// Watches the tick, result and configuration channels of the button press and
// LED sequencer. Keeps its own copy of the timing registers and of the
// debounce, hold timer and LED phase state, works out the result word of
// every accepted tick and compares each accepted result word, field by field,
// with the oldest word still due.
// ----------------------------------------------------------------------------
module bpls_sequence_checker
  import bpls_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  bpls_in_if          in_i,
  bpls_out_if         res_i,
  bpls_cfg_if         cfg_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // timing registers as last written
  logic [7:0]           dbnc_cfg;
  logic [TimerBits-1:0] short_min_cfg, hold_cfg, step_cfg, post_wait_cfg;
  logic [TimerBits-1:0] auth_half_cfg, flash_cfg, retry_cfg;

  // button and sequencer state
  logic                 raw_seen, level_q, down_q, reset_fired_q, led_q;
  logic [TimerBits-1:0] age_q, hold_time_q, elapsed_q, duration_q;
  logic [1:0]           misses_q;
  phase_e               phase_q;

  bpls_out_t   led_words_due [$];
  int unsigned mismatches;

  function automatic logic [TimerBits-1:0] sat_up(logic [TimerBits-1:0] v);
    return (v == TimerMax) ? v : v + 1'b1;
  endfunction

  function automatic void arm(logic [TimerBits-1:0] d);
    elapsed_q  = '0;
    duration_q = d;
  endfunction

  function automatic logic auth_blinking();
    return (phase_q == PhAuthOn) || (phase_q == PhAuthOff);
  endfunction

  // one tick: command, debounce, hold timing, then at most one phase step
  function automatic bpls_out_t next_led_word(bpls_in_t w);
    bpls_out_t            res;
    phase_e               nxt;
    logic [TimerBits-1:0] dur;
    logic                 lvl, tabled;
    res = '0;
    elapsed_q = sat_up(elapsed_q);

    // auth blink command
    if (w.command == CmdAuthOff) begin
      if (auth_blinking()) begin
        led_q   = 1'b0;
        phase_q = PhIdle;
      end
    end else if (w.command == CmdAuthOn) begin
      if (phase_q == PhIdle) begin
        phase_q = PhAuthOn;
        led_q   = 1'b1;
        arm(auth_half_cfg);
      end
    end

    // debounce
    if (w.raw_button != raw_seen) begin
      raw_seen = w.raw_button;
      age_q    = '0;
    end else begin
      age_q = sat_up(age_q);
    end
    if (age_q >= {8'd0, dbnc_cfg}) level_q = raw_seen;

    // hold timing: long hold asks for factory reset, release may start things
    if (level_q) begin
      if (!down_q) begin
        down_q        = 1'b1;
        hold_time_q   = '0;
        reset_fired_q = 1'b0;
      end else begin
        hold_time_q = sat_up(hold_time_q);
        if (!reset_fired_q && hold_time_q >= hold_cfg) begin
          reset_fired_q             = 1'b1;
          res.factory_reset_request = !w.update_in_progress;
        end
      end
    end else if (down_q) begin
      hold_time_q = sat_up(hold_time_q);
      if (!reset_fired_q && hold_time_q >= short_min_cfg && hold_time_q < hold_cfg) begin
        if (auth_blinking()) begin
          res.auth_short_press = 1'b1;
        end else if (phase_q == PhIdle && !w.access_point_mode && w.broker_configured) begin
          phase_q = PhPreOn1;
          led_q   = 1'b1;
          arm(step_cfg);
        end
      end
      down_q        = 1'b0;
      reset_fired_q = 1'b0;
    end

    // phase step once the current phase has run its time
    if (phase_q != PhIdle && elapsed_q >= duration_q) begin
      tabled = 1'b1;
      lvl    = 1'b0;
      dur    = step_cfg;
      nxt    = phase_q;
      case (phase_q)
        PhPreOn1:   nxt = PhPreOff1;
        PhPreOff1:  begin nxt = PhPreOn2; lvl = 1'b1; end
        PhPreOn2:   nxt = PhPreOff2;
        PhPostWait: begin nxt = PhPostOn1; lvl = 1'b1; end
        PhPostOn1:  nxt = PhPostOff1;
        PhPostOff1: begin nxt = PhPostOn2; lvl = 1'b1; end
        PhPostOn2:  nxt = PhPostOff2;
        PhFailOn1:  begin nxt = PhFailOff1; dur = flash_cfg; end
        PhFailOff1: begin nxt = PhFailOn2; lvl = 1'b1; dur = flash_cfg; end
        PhFailOn2:  begin nxt = PhFailOff2; dur = flash_cfg; end
        PhFailOff2: begin nxt = PhFailOn3; lvl = 1'b1; dur = flash_cfg; end
        PhFailOn3:  begin nxt = PhFailOff3; dur = flash_cfg; end
        PhAuthOn:   begin nxt = PhAuthOff; dur = auth_half_cfg; end
        PhAuthOff:  begin nxt = PhAuthOn; lvl = 1'b1; dur = auth_half_cfg; end
        default:    tabled = 1'b0;
      endcase
      if (tabled) begin
        led_q   = lvl;
        phase_q = nxt;
        arm(dur);
      end else begin
        case (phase_q)
          PhPreOff2: begin
            misses_q = '0;
            phase_q  = PhTry;
            arm('0);
          end
          PhTry: begin
            res.publish_attempt = 1'b1;
            if (w.publish_ok) begin
              phase_q = PhPostWait;
              arm(post_wait_cfg);
            end else begin
              misses_q = misses_q + 1'b1;
              if (misses_q >= MaxAttempts) begin
                led_q   = 1'b1;
                phase_q = PhFailOn1;
                arm(flash_cfg);
              end else begin
                phase_q = PhRetryWait;
                arm(retry_cfg);
              end
            end
          end
          PhRetryWait: begin
            phase_q = PhTry;
            arm('0);
          end
          PhPostOff2, PhFailOff3: phase_q = PhIdle;
          default: ;
        endcase
      end
    end

    res.led_level         = led_q;
    res.led_hold          = (phase_q == PhIdle);
    res.sequence_active   = (phase_q != PhIdle);
    res.auth_blink_active = auth_blinking();
    res.button_level      = level_q;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 50) $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic want, logic got);
    if (want !== got) report_mismatch($sformatf("%s expected %b got %b", name, want, got));
  endtask

  // watch the channels at every rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    bpls_out_t want;
    if (!rst_ni) begin
      dbnc_cfg      = DebounceRst;
      short_min_cfg = ShortMinRst;
      hold_cfg      = ResetHoldRst;
      step_cfg      = StepRst;
      post_wait_cfg = PostWaitRst;
      auth_half_cfg = AuthHalfRst;
      flash_cfg     = FailFlashRst;
      retry_cfg     = RetryWaitRst;
      raw_seen      = 1'b0;
      level_q       = 1'b0;
      down_q        = 1'b0;
      reset_fired_q = 1'b0;
      led_q         = 1'b0;
      age_q         = '0;
      hold_time_q   = '0;
      elapsed_q     = '0;
      duration_q    = '0;
      misses_q      = '0;
      phase_q       = PhIdle;
      led_words_due.delete();
      mismatches    = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // result word against the oldest one due
      if (res_i.valid && res_i.ready) begin
        if (led_words_due.size() == 0) begin
          report_mismatch("result word with nothing due");
        end else begin
          want = led_words_due.pop_front();
          check_field("led_level", want.led_level, res_i.data.led_level);
          check_field("led_hold", want.led_hold, res_i.data.led_hold);
          check_field("publish_attempt", want.publish_attempt, res_i.data.publish_attempt);
          check_field("factory_reset_request", want.factory_reset_request,
                      res_i.data.factory_reset_request);
          check_field("auth_short_press", want.auth_short_press,
                      res_i.data.auth_short_press);
          check_field("sequence_active", want.sequence_active, res_i.data.sequence_active);
          check_field("auth_blink_active", want.auth_blink_active,
                      res_i.data.auth_blink_active);
          check_field("button_level", want.button_level, res_i.data.button_level);
        end
      end

      // register write
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.data.index)
          RegDebounce:  dbnc_cfg      = cfg_i.data.data[7:0];
          RegShortMin:  short_min_cfg = cfg_i.data.data;
          RegResetHold: hold_cfg      = cfg_i.data.data;
          RegStep:      step_cfg      = cfg_i.data.data;
          RegPostWait:  post_wait_cfg = cfg_i.data.data;
          RegAuthHalf:  auth_half_cfg = cfg_i.data.data;
          RegFailFlash: flash_cfg     = cfg_i.data.data;
          RegRetryWait: retry_cfg     = cfg_i.data.data;
          default: ;
        endcase
      end

      // accepted tick
      if (in_i.valid && in_i.ready) led_words_due.push_back(next_led_word(in_i.data));

      fail_count_o <= mismatches;
      pending_o    <= led_words_due.size();
    end
  end

endmodule

### tb/tb_button_press_led_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_press_led_sequencer
// Drives millisecond ticks into the button press and LED sequencer: a short
// directed run over commands, short and long presses and the start blockers,
// then button traffic under several timing settings, from the floor values to
// the ceiling values. Both channel sides idle at random; once the result side
// holds off long enough to stall the tick input. The checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_button_press_led_sequencer;
  import bpls_pkg::*;

  localparam logic [1:0]  CmdUnused  = 2'd3;
  localparam int unsigned StallLimit = 1000;

  logic clk;
  logic rst_n;

  bpls_in_if  in_ch ();
  bpls_out_if out_ch ();
  bpls_cfg_if cfg_ch ();

  bit          steady;
  bit          squeeze_armed;
  int unsigned cfg_now [8];
  int unsigned mismatches;
  int unsigned words_due;
  int unsigned quiet_cycles;

  button_press_led_sequencer u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  bpls_sequence_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_i         (in_ch),
    .res_i        (out_ch),
    .cfg_i        (cfg_ch),
    .fail_count_o (mismatches),
    .pending_o    (words_due)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int unsigned stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_armed) begin
        squeeze_armed = 1'b0;
        stall_left    = 64;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= 20);
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("FAIL button_press_led_sequencer");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // write all timing registers from cfg_now, back to back
  task automatic load_timings();
    for (int i = RegDebounce; i <= RegRetryWait; i++) begin
      cfg_ch.valid      <= 1'b1;
      cfg_ch.data.index <= i[CfgIdxBits-1:0];
      cfg_ch.data.data  <= cfg_now[i][CfgDataBits-1:0];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // offer one tick word, with a random gap in front unless running steady
  task automatic send_tick(input logic raw, input logic [1:0] cmd, input logic ok,
                           input logic broker, input logic ap, input logic upd);
    bpls_in_t w;
    w.raw_button         = raw;
    w.command            = cmd;
    w.publish_ok         = ok;
    w.broker_configured  = broker;
    w.access_point_mode  = ap;
    w.update_in_progress = upd;
    if (!steady && $urandom_range(99) < 20) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop offering and wait until every result word is back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
    repeat (2) @(posedge clk);
  endtask

  // presses of shaped length with bounce, commands and status noise
  task automatic press_traffic(input int unsigned n_ticks, input bit squeeze_mid);
    int unsigned run_left, r, deb;
    logic        lvl;
    logic [1:0]  cmd;
    lvl      = 1'b0;
    run_left = 0;
    deb      = cfg_now[RegDebounce];
    for (int unsigned k = 0; k < n_ticks; k++) begin
      if (run_left == 0) begin
        lvl = !lvl;
        r   = $urandom_range(99);
        if (!lvl) begin
          run_left = (r < 15) ? $urandom_range(deb + 1, 1) : deb + $urandom_range(40, 1);
        end else if (r < 15) begin
          // at most just long enough to pass the debounce
          run_left = $urandom_range(deb + 1, 1);
        end else if (r < 30 && cfg_now[RegResetHold] < 200) begin
          run_left = deb + cfg_now[RegResetHold] + $urandom_range(5, 1);
        end else begin
          run_left = deb + cfg_now[RegShortMin] + $urandom_range(5, 1);
        end
      end
      run_left--;
      r = $urandom_range(99);
      if (r < 88)      cmd = CmdNone;
      else if (r < 93) cmd = CmdAuthOn;
      else if (r < 98) cmd = CmdAuthOff;
      else             cmd = CmdUnused;
      send_tick(($urandom_range(99) < 3) ? !lvl : lvl, cmd, 1'($urandom_range(1)),
                $urandom_range(99) >= 8, $urandom_range(99) < 8,
                $urandom_range(99) < 15);
      if (squeeze_mid && k == n_ticks / 2) squeeze_armed = 1'b1;
    end
  endtask

  // stimulus and verdict
  initial begin
    rst_n         = 1'b0;
    steady        = 1'b0;
    squeeze_armed = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: instant debounce, one tick short press, three tick long hold
    cfg_now[RegDebounce]  = 0;
    cfg_now[RegShortMin]  = 1;
    cfg_now[RegResetHold] = 2;
    cfg_now[RegStep]      = 0;
    cfg_now[RegPostWait]  = 0;
    cfg_now[RegAuthHalf]  = 0;
    cfg_now[RegFailFlash] = 0;
    cfg_now[RegRetryWait] = 0;
    load_timings();
    send_tick(1'b0, CmdNone,    1'b0, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0, CmdAuthOn,  1'b0, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0, CmdUnused,  1'b1, 1'b1, 1'b0, 1'b0);
    // short press while blinking gives the auth pulse
    send_tick(1'b1, CmdNone,    1'b0, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0, CmdNone,    1'b0, 1'b1, 1'b0, 1'b0);
    // auth on while busy is ignored, auth off twice
    send_tick(1'b0, CmdAuthOn,  1'b0, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0, CmdAuthOff, 1'b0, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0, CmdAuthOff, 1'b0, 1'b1, 1'b0, 1'b0);
    // long hold raises the factory reset request
    repeat (3) send_tick(1'b1, CmdNone, 1'b0, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0, CmdNone,    1'b0, 1'b1, 1'b0, 1'b0);
    // long hold during an update is swallowed
    repeat (3) send_tick(1'b1, CmdNone, 1'b0, 1'b1, 1'b0, 1'b1);
    send_tick(1'b0, CmdNone,    1'b0, 1'b1, 1'b0, 1'b1);
    // no broker, then access point mode: nothing starts
    send_tick(1'b1, CmdNone,    1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, CmdNone,    1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, CmdNone,    1'b0, 1'b1, 1'b1, 1'b0);
    send_tick(1'b0, CmdNone,    1'b0, 1'b1, 1'b1, 1'b0);
    // good press runs the transmit sequence with zero length phases
    send_tick(1'b1, CmdNone,    1'b0, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0, CmdNone,    1'b0, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0, CmdNone,    1'b1, 1'b1, 1'b1, 1'b1);
    send_tick(1'b0, CmdNone,    1'b0, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0, CmdNone,    1'b0, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0, CmdNone,    1'b1, 1'b1, 1'b0, 1'b0);
    wait_drained();

    // random traffic under several timing settings
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) begin
        cfg_now[RegDebounce]  = DebounceRst;
        cfg_now[RegShortMin]  = ShortMinRst;
        cfg_now[RegResetHold] = ResetHoldRst;
        cfg_now[RegStep]      = StepRst;
        cfg_now[RegPostWait]  = PostWaitRst;
        cfg_now[RegAuthHalf]  = AuthHalfRst;
        cfg_now[RegFailFlash] = FailFlashRst;
        cfg_now[RegRetryWait] = RetryWaitRst;
      end else if (ph == 1) begin
        cfg_now[RegDebounce]  = 1;
        cfg_now[RegShortMin]  = 0;
        cfg_now[RegResetHold] = 1;
        cfg_now[RegStep]      = 0;
        cfg_now[RegPostWait]  = 0;
        cfg_now[RegAuthHalf]  = 0;
        cfg_now[RegFailFlash] = 0;
        cfg_now[RegRetryWait] = 0;
      end else begin
        cfg_now[RegDebounce]  = $urandom_range(4);
        cfg_now[RegShortMin]  = $urandom_range(10);
        cfg_now[RegResetHold] = $urandom_range(60, 3);
        cfg_now[RegStep]      = $urandom_range(8);
        cfg_now[RegPostWait]  = $urandom_range(12);
        cfg_now[RegAuthHalf]  = $urandom_range(12);
        cfg_now[RegFailFlash] = $urandom_range(6);
        cfg_now[RegRetryWait] = $urandom_range(8);
      end
      load_timings();
      steady = (ph == 3);
      press_traffic(200, ph == 2);
      wait_drained();
    end
    steady = 1'b0;

    // ceiling values: slowest debounce, a hold far below the limits, steady blink
    cfg_now[RegDebounce] = 255;
    for (int i = RegShortMin; i <= RegRetryWait; i++) cfg_now[i] = 65535;
    load_timings();
    for (int unsigned k = 0; k < 400; k++) begin
      send_tick(k > 0 && k < 330,
                (k == 0) ? CmdAuthOn : ((k == 399) ? CmdAuthOff : CmdNone),
                1'($urandom_range(1)), 1'b1, 1'b0, 1'b0);
    end
    wait_drained();

    if (mismatches == 0) begin
      $display("PASS button_press_led_sequencer");
    end else begin
      $display("FAIL button_press_led_sequencer");
    end
    $finish;
  end

endmodule

### button_press_led_sequencer.f
rtl/bpls_pkg.sv
rtl/bpls_if.sv
rtl/button_press_led_sequencer.sv
tb/bpls_sequence_checker.sv
tb/tb_button_press_led_sequencer.sv
